// File: rtl/lr_pkg.sv
// Shared types and fixed widths for the line rasterizer.
package lr_pkg;

    localparam int CoordW = 17;
    localparam int WrapW  = 12;

    typedef struct packed {
        logic        valid_res;
        logic        last;
        logic [31:0] color;
    } lr_meta_t;

    typedef struct packed {
        lr_meta_t                   meta;
        logic signed [CoordW-1:0]   x;
        logic signed [CoordW-1:0]   y;
    } lr_raw_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } lr_op_t;

endpackage

// File: rtl/lr_walker.sv
// Input register and Bresenham line state, producing one raw pixel word per item.
module lr_walker import lr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_x_start,
    input  logic [15:0] s_y_start,
    input  logic [15:0] s_x_end,
    input  logic [15:0] s_y_end,
    input  logic [31:0] pen_color,
    output logic        raw_valid,
    input  logic        raw_ready,
    output lr_raw_t     raw_word
);

    logic        a_valid_reg;
    lr_op_t      a_op_reg;
    logic [15:0] a_xs_reg, a_ys_reg, a_xe_reg, a_ye_reg;
    logic        a_en, b_en, take;

    logic                     b_valid_reg;
    lr_raw_t                  b_word_reg;

    logic signed [CoordW-1:0] cur_x_reg, cur_y_reg, major_end_reg;
    logic signed [CoordW-1:0] cur_x_next, cur_y_next, major_end_next;
    logic [CoordW-1:0]        abs_dx_reg, abs_dy_reg, abs_dx_next, abs_dy_next;
    logic signed [19:0]       error_term_reg, error_term_next;
    logic                     x_major_reg, minor_up_reg, line_active_reg;
    logic                     x_major_next, minor_up_next, line_active_next;
    lr_raw_t                  word_next;

    assign b_en      = !b_valid_reg || raw_ready;
    assign a_en      = !a_valid_reg || b_en;
    assign take      = a_valid_reg && b_en;
    assign s_ready   = a_en;
    assign raw_valid = b_valid_reg;
    assign raw_word  = b_word_reg;

    always_comb begin
        logic signed [CoordW-1:0] x1, y1, x2, y2, dx, dy;
        logic                     done;
        x1 = {a_xs_reg[15], a_xs_reg};
        y1 = {a_ys_reg[15], a_ys_reg};
        x2 = {a_xe_reg[15], a_xe_reg};
        y2 = {a_ye_reg[15], a_ye_reg};
        dx = x2 - x1;
        dy = y2 - y1;
        done = 1'b0;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        error_term_next  = error_term_reg;
        x_major_next     = x_major_reg;
        minor_up_next    = minor_up_reg;
        line_active_next = line_active_reg;
        word_next        = '0;
        if (a_op_reg == OP_START) begin
            abs_dx_next   = dx[CoordW-1] ? CoordW'(-dx) : CoordW'(dx);
            abs_dy_next   = dy[CoordW-1] ? CoordW'(-dy) : CoordW'(dy);
            minor_up_next = (dx[CoordW-1] && dy[CoordW-1]) ||
                            (!dx[CoordW-1] && dx != '0 && !dy[CoordW-1] && dy != '0);
            x_major_next  = abs_dy_next <= abs_dx_next;
            if (x_major_next) begin
                error_term_next = 20'({abs_dy_next, 1'b0}) - 20'(abs_dx_next);
                if (!dx[CoordW-1]) begin
                    cur_x_next = x1; cur_y_next = y1; major_end_next = x2;
                end else begin
                    cur_x_next = x2; cur_y_next = y2; major_end_next = x1;
                end
                done = cur_x_next >= major_end_next;
            end else begin
                error_term_next = 20'({abs_dx_next, 1'b0}) - 20'(abs_dy_next);
                if (!dy[CoordW-1]) begin
                    cur_x_next = x1; cur_y_next = y1; major_end_next = y2;
                end else begin
                    cur_x_next = x2; cur_y_next = y2; major_end_next = y1;
                end
                done = cur_y_next >= major_end_next;
            end
            line_active_next = !done;
            word_next.meta.valid_res = 1'b1;
            word_next.meta.last      = done;
            word_next.meta.color     = pen_color;
            word_next.x              = cur_x_next;
            word_next.y              = cur_y_next;
        end else if (line_active_reg) begin
            if (x_major_reg) begin
                cur_x_next = cur_x_reg + 17'sd1;
                if (error_term_reg[19]) begin
                    error_term_next = error_term_reg + 20'({abs_dy_reg, 1'b0});
                end else begin
                    cur_y_next = minor_up_reg ? cur_y_reg + 17'sd1 : cur_y_reg - 17'sd1;
                    error_term_next = error_term_reg + 20'({abs_dy_reg, 1'b0})
                                      - 20'({abs_dx_reg, 1'b0});
                end
                done = cur_x_next >= major_end_reg;
            end else begin
                cur_y_next = cur_y_reg + 17'sd1;
                if (error_term_reg[19] || error_term_reg == '0) begin
                    error_term_next = error_term_reg + 20'({abs_dx_reg, 1'b0});
                end else begin
                    cur_x_next = minor_up_reg ? cur_x_reg + 17'sd1 : cur_x_reg - 17'sd1;
                    error_term_next = error_term_reg + 20'({abs_dx_reg, 1'b0})
                                      - 20'({abs_dy_reg, 1'b0});
                end
                done = cur_y_next >= major_end_reg;
            end
            line_active_next = !done;
            word_next.meta.valid_res = 1'b1;
            word_next.meta.last      = done;
            word_next.meta.color     = pen_color;
            word_next.x              = cur_x_next;
            word_next.y              = cur_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            error_term_reg  <= '0;
            x_major_reg     <= 1'b0;
            minor_up_reg    <= 1'b0;
            line_active_reg <= 1'b0;
        end else begin
            if (a_en) begin
                a_valid_reg <= s_valid;
            end
            if (b_en) begin
                b_valid_reg <= a_valid_reg;
            end
            if (take) begin
                cur_x_reg       <= cur_x_next;
                cur_y_reg       <= cur_y_next;
                major_end_reg   <= major_end_next;
                abs_dx_reg      <= abs_dx_next;
                abs_dy_reg      <= abs_dy_next;
                error_term_reg  <= error_term_next;
                x_major_reg     <= x_major_next;
                minor_up_reg    <= minor_up_next;
                line_active_reg <= line_active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_op_reg <= lr_op_t'(s_opcode);
            a_xs_reg <= s_x_start;
            a_ys_reg <= s_y_start;
            a_xe_reg <= s_x_end;
            a_ye_reg <= s_y_end;
        end
        if (take) begin
            b_word_reg <= word_next;
        end
    end

endmodule

// File: rtl/lr_addr_map.sv
// Pipeline that wraps raw coordinates onto the screen and forms the framebuffer address.
module lr_addr_map import lr_pkg::*; #(
    parameter int FB_WIDTH  = 1024,
    parameter int FB_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        raw_valid,
    output logic        raw_ready,
    input  lr_raw_t     raw_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [9:0]  m_pixel_x,
    output logic [9:0]  m_pixel_y,
    output logic [19:0] m_pixel_address,
    output logic [31:0] m_color,
    output logic        m_last
);

    localparam logic [12:0] W_C    = 13'(FB_WIDTH);
    localparam logic [12:0] H_C    = 13'(FB_HEIGHT);
    localparam int          OFF_X  = FB_WIDTH * ((65536 + FB_WIDTH - 1) / FB_WIDTH);
    localparam int          OFF_Y  = FB_HEIGHT * ((65536 + FB_HEIGHT - 1) / FB_HEIGHT);
    localparam int          SHIFT_X = 18 + $clog2(FB_WIDTH);
    localparam int          SHIFT_Y = 18 + $clog2(FB_HEIGHT);
    localparam longint      RECIP_X = ((64'd1 << SHIFT_X) + FB_WIDTH - 1) / FB_WIDTH;
    localparam longint      RECIP_Y = ((64'd1 << SHIFT_Y) + FB_HEIGHT - 1) / FB_HEIGHT;

    logic              c_valid_reg, d_valid_reg, e_valid_reg;
    logic              c_en, d_en, e_en;
    lr_meta_t          c_meta_reg, d_meta_reg, e_meta_reg;
    logic [17:0]       c_vx_reg, c_vy_reg, c_qx_reg, c_qy_reg;
    logic [WrapW-1:0]  d_rx_reg, d_ry_reg;
    logic [9:0]        e_px_reg, e_py_reg;
    logic [19:0]       e_addr_reg;

    logic [17:0]       vx, vy;
    logic [37:0]       prod_x, prod_y;
    logic [17:0]       rx, ry;
    logic [23:0]       addr;

    assign e_en      = !e_valid_reg || m_ready;
    assign d_en      = !d_valid_reg || e_en;
    assign c_en      = !c_valid_reg || d_en;
    assign raw_ready = c_en;

    assign vx     = 18'({raw_word.x[CoordW-1], raw_word.x}) + 18'(OFF_X);
    assign vy     = 18'({raw_word.y[CoordW-1], raw_word.y}) + 18'(OFF_Y);
    assign prod_x = 38'(vx) * 38'(RECIP_X);
    assign prod_y = 38'(vy) * 38'(RECIP_Y);

    always_comb begin
        logic [17:0] tx, ty;
        tx = c_vx_reg - 18'(c_qx_reg * W_C);
        ty = c_vy_reg - 18'(c_qy_reg * H_C);
        rx = (tx >= 18'(W_C)) ? tx - 18'(W_C) : tx;
        ry = (ty >= 18'(H_C)) ? ty - 18'(H_C) : ty;
    end

    assign addr = 24'(d_ry_reg) * 24'(W_C) + 24'(d_rx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (c_en) begin
                c_valid_reg <= raw_valid;
            end
            if (d_en) begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_en) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            c_meta_reg <= raw_word.meta;
            c_vx_reg   <= vx;
            c_vy_reg   <= vy;
            c_qx_reg   <= 18'(prod_x >> SHIFT_X);
            c_qy_reg   <= 18'(prod_y >> SHIFT_Y);
        end
        if (d_en) begin
            d_meta_reg <= c_meta_reg;
            d_rx_reg   <= WrapW'(rx);
            d_ry_reg   <= WrapW'(ry);
        end
        if (e_en) begin
            e_meta_reg <= d_meta_reg;
            e_px_reg   <= d_rx_reg[9:0];
            e_py_reg   <= d_ry_reg[9:0];
            e_addr_reg <= addr[19:0];
        end
    end

    assign m_valid         = e_valid_reg;
    assign m_valid_res     = e_meta_reg.valid_res;
    assign m_last          = e_meta_reg.last;
    assign m_color         = e_meta_reg.color;
    assign m_pixel_x       = e_px_reg;
    assign m_pixel_y       = e_py_reg;
    assign m_pixel_address = e_addr_reg;

endmodule

// File: rtl/line_rasterizer_wrapped.sv
// Top level of the Bresenham line rasterizer with screen wrap and address output.
// An accepted word passes the input register, the line state and the wrap and address stages.
// Throughput: one word per cycle unless m_ready stalls the result port; the line state is updated once per word.
// The wrap and address stages are pipelined and add latency only.
// Reset is synchronous and active low; it clears the line state, the color and the valid flags of all stages.
module line_rasterizer_wrapped import lr_pkg::*; #(
    parameter int FB_WIDTH  = 1024,
    parameter int FB_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_x_start,
    input  logic [15:0] s_y_start,
    input  logic [15:0] s_x_end,
    input  logic [15:0] s_y_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [9:0]  m_pixel_x,
    output logic [9:0]  m_pixel_y,
    output logic [19:0] m_pixel_address,
    output logic [31:0] m_color,
    output logic        m_last
);

    logic [31:0] pen_color_reg;
    logic        raw_valid, raw_ready;
    lr_raw_t     raw_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_color_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            pen_color_reg <= cfg_data;
        end
    end

    lr_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_x_start  (s_x_start),
        .s_y_start  (s_y_start),
        .s_x_end    (s_x_end),
        .s_y_end    (s_y_end),
        .pen_color  (pen_color_reg),
        .raw_valid  (raw_valid),
        .raw_ready  (raw_ready),
        .raw_word   (raw_word)
    );

    lr_addr_map #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_addr_map (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .raw_valid       (raw_valid),
        .raw_ready       (raw_ready),
        .raw_word        (raw_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_valid_res     (m_valid_res),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_pixel_address (m_pixel_address),
        .m_color         (m_color),
        .m_last          (m_last)
    );

`ifndef SYNTHESIS
    // A word without a pixel carries all zero fields.
    a_empty_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_pixel_x == '0 && m_pixel_y == '0 &&
            m_pixel_address == '0 && m_color == '0 && !m_last))
        else $error("empty result word has nonzero fields");

    // The final pixel of a line is always a real pixel.
    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> m_valid_res)
        else $error("last flag on a word without a pixel");

    // Reset empties the result stage.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

// File: tb/line_rasterizer_checker.sv
// Checker that predicts every pixel word of the line rasterizer and compares it on the result port.
module line_rasterizer_checker import lr_pkg::*; #(
    parameter int FB_WIDTH  = 1024,
    parameter int FB_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_x_start,
    input  logic [15:0] s_y_start,
    input  logic [15:0] s_x_end,
    input  logic [15:0] s_y_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_valid_res,
    input  logic [9:0]  m_pixel_x,
    input  logic [9:0]  m_pixel_y,
    input  logic [19:0] m_pixel_address,
    input  logic [31:0] m_color,
    input  logic        m_last,
    output int          fail_count,
    output int          words_out
);

    typedef struct packed {
        logic        valid_res;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [19:0] address;
        logic [31:0] color;
        logic        last;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic [31:0]              color_reg;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] major_stop;
    logic [CoordW-1:0]        span_x;
    logic [CoordW-1:0]        span_y;
    logic signed [19:0]       decision;
    logic                     along_x;
    logic                     minor_rises;
    logic                     drawing;

    function automatic int wrap_coord(logic signed [CoordW-1:0] v, int n);
        int r;
        r = int'(v) % n;
        if (r < 0) r += n;
        return r;
    endfunction

    function automatic pixel_t place_pixel(logic is_last);
        pixel_t p;
        int     px;
        int     py;
        int     addr;
        px = wrap_coord(pos_x, FB_WIDTH);
        py = wrap_coord(pos_y, FB_HEIGHT);
        addr = py * FB_WIDTH + px;
        p.valid_res = 1'b1;
        p.x = px[9:0];
        p.y = py[9:0];
        p.address = addr[19:0];
        p.color = color_reg;
        p.last = is_last;
        return p;
    endfunction

    function automatic pixel_t rasterize_word(lr_op_t op, logic signed [15:0] x1,
                                              logic signed [15:0] y1, logic signed [15:0] x2,
                                              logic signed [15:0] y2);
        logic signed [CoordW-1:0] dx;
        logic signed [CoordW-1:0] dy;
        logic signed [19:0]       twice_x;
        logic signed [19:0]       twice_y;
        logic                     done;
        if (op == OP_START) begin
            dx = x2 - x1;
            dy = y2 - y1;
            span_x = dx < 0 ? -dx : dx;
            span_y = dy < 0 ? -dy : dy;
            minor_rises = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
            along_x = span_y <= span_x;
            twice_x = {2'b00, span_x, 1'b0};
            twice_y = {2'b00, span_y, 1'b0};
            if (along_x) begin
                decision = twice_y - {3'b000, span_x};
                if (dx >= 0) begin
                    pos_x = x1;
                    pos_y = y1;
                    major_stop = x2;
                end else begin
                    pos_x = x2;
                    pos_y = y2;
                    major_stop = x1;
                end
                done = pos_x >= major_stop;
            end else begin
                decision = twice_x - {3'b000, span_y};
                if (dy >= 0) begin
                    pos_x = x1;
                    pos_y = y1;
                    major_stop = y2;
                end else begin
                    pos_x = x2;
                    pos_y = y2;
                    major_stop = y1;
                end
                done = pos_y >= major_stop;
            end
            drawing = !done;
            return place_pixel(done);
        end
        if (!drawing) return '0;
        twice_x = {2'b00, span_x, 1'b0};
        twice_y = {2'b00, span_y, 1'b0};
        if (along_x) begin
            pos_x = pos_x + 17'sd1;
            if (decision < 0) begin
                decision = decision + twice_y;
            end else begin
                pos_y = minor_rises ? pos_y + 17'sd1 : pos_y - 17'sd1;
                decision = decision + twice_y - twice_x;
            end
            done = pos_x >= major_stop;
        end else begin
            pos_y = pos_y + 17'sd1;
            if (decision <= 0) begin
                decision = decision + twice_x;
            end else begin
                pos_x = minor_rises ? pos_x + 17'sd1 : pos_x - 17'sd1;
                decision = decision + twice_x - twice_y;
            end
            done = pos_y >= major_stop;
        end
        if (done) drawing = 1'b0;
        return place_pixel(done);
    endfunction

    task automatic note_failure(string what, pixel_t want, pixel_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s: expected valid_res=%0b x=%0d y=%0d addr=%0d color=%h last=%0b",
                     $time, what, want.valid_res, want.x, want.y, want.address, want.color,
                     want.last);
            $display("    actual valid_res=%0b x=%0d y=%0d addr=%0d color=%h last=%0b",
                     got.valid_res, got.x, got.y, got.address, got.color, got.last);
        end
    endtask

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        pixel_t fresh;
        if (!aresetn) begin
            color_reg = '0;
            pos_x = '0;
            pos_y = '0;
            major_stop = '0;
            span_x = '0;
            span_y = '0;
            decision = '0;
            along_x = 1'b0;
            minor_rises = 1'b0;
            drawing = 1'b0;
            fail_count = 0;
            expected_pixels.delete();
            words_out <= 0;
        end else begin
            if (cfg_valid && cfg_ready) color_reg = cfg_data;
            if (m_valid && m_ready) begin
                got = {m_valid_res, m_pixel_x, m_pixel_y, m_pixel_address, m_color, m_last};
                words_out <= words_out + 1;
                if (expected_pixels.size() == 0) begin
                    note_failure("unexpected word", '0, got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) note_failure("mismatch", want, got);
                end
            end
            if (s_valid && s_ready) begin
                fresh = rasterize_word(lr_op_t'(s_opcode), s_x_start, s_y_start, s_x_end,
                                       s_y_end);
                expected_pixels.insert(expected_pixels.size(), fresh);
            end
        end
    end

endmodule

// File: tb/line_rasterizer_wrapped_tb.sv
// Testbench top for the line rasterizer: clock, reset, line and color stimulus, and the verdict.
module line_rasterizer_wrapped_tb import lr_pkg::*;;

    localparam int ScreenW = 1024;
    localparam int ScreenH = 1024;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic [15:0] s_x_start = '0;
    logic [15:0] s_y_start = '0;
    logic [15:0] s_x_end = '0;
    logic [15:0] s_y_end = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic        m_valid_res;
    logic [9:0]  m_pixel_x;
    logic [9:0]  m_pixel_y;
    logic [19:0] m_pixel_address;
    logic [31:0] m_color;
    logic        m_last;

    int   fail_count;
    int   words_out;
    int   words_in = 0;
    int   stall_left = 0;
    logic gaps_on = 1'b0;

    line_rasterizer_wrapped #(
        .FB_WIDTH (ScreenW),
        .FB_HEIGHT(ScreenH)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_x_start      (s_x_start),
        .s_y_start      (s_y_start),
        .s_x_end        (s_x_end),
        .s_y_end        (s_y_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_address(m_pixel_address),
        .m_color        (m_color),
        .m_last         (m_last)
    );

    line_rasterizer_checker #(
        .FB_WIDTH (ScreenW),
        .FB_HEIGHT(ScreenH)
    ) pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_x_start      (s_x_start),
        .s_y_start      (s_y_start),
        .s_x_end        (s_x_end),
        .s_y_end        (s_y_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_address(m_pixel_address),
        .m_color        (m_color),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .words_out      (words_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 11) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(lr_op_t op, logic [15:0] x1, logic [15:0] y1,
                             logic [15:0] x2, logic [15:0] y2);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_x_start <= x1;
        s_y_start <= y1;
        s_x_end <= x2;
        s_y_end <= y2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_in++;
    endtask

    task automatic step_word();
        send_word(OP_STEP, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic write_color(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (words_out != words_in) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int rand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic draw_random_line();
        int x1;
        int y1;
        int x2;
        int y2;
        int len;
        int len_y;
        int steps;
        x1 = rand16();
        y1 = rand16();
        if ($urandom_range(0, 15) == 0) begin
            x2 = rand16();
            y2 = rand16();
            steps = $urandom_range(0, 8);
        end else begin
            if ($urandom_range(0, 7) == 0) x1 = $urandom_range(0, 1) ? 32767 : -32768;
            if ($urandom_range(0, 7) == 0) y1 = $urandom_range(0, 1) ? 32767 : -32768;
            x2 = clamp16(x1 + int'($urandom_range(0, 60)) - 30);
            y2 = clamp16(y1 + int'($urandom_range(0, 60)) - 30);
            len = x2 > x1 ? x2 - x1 : x1 - x2;
            len_y = y2 > y1 ? y2 - y1 : y1 - y2;
            if (len_y > len) len = len_y;
            steps = len;
            if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, len);
            else if ($urandom_range(0, 3) == 0) steps = len + $urandom_range(1, 2);
        end
        send_word(OP_START, x1[15:0], y1[15:0], x2[15:0], y2[15:0]);
        repeat (steps) step_word();
    endtask

    task automatic run_phase(int target, logic [31:0] value, logic with_gaps);
        drain();
        write_color(value);
        gaps_on <= with_gaps;
        while (words_in < target) begin
            if ($urandom_range(0, 9) == 0) step_word();
            else draw_random_line();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        write_color(32'hFFFF_FFFF);
        step_word();
        send_word(OP_START, 16'd5, 16'd5, 16'd5, 16'd5);
        step_word();
        send_word(OP_START, 16'd0, 16'd0, 16'd4, 16'd2);
        repeat (5) step_word();
        send_word(OP_START, 16'd3, -16'sd2, -16'sd3, 16'd2);
        repeat (6) step_word();
        send_word(OP_START, -16'sd1, -16'sd1, 16'd1, -16'sd5);
        repeat (4) step_word();
        send_word(OP_START, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        repeat (2) step_word();
        send_word(OP_START, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        step_word();

        run_phase(430, $urandom, 1'b1);
        run_phase(800, 32'h0000_0000, 1'b0);
        run_phase(1180, $urandom, 1'b1);
        run_phase(1550, $urandom, 1'b0);

        drain();
        repeat (12) @(posedge aclk);
        if (fail_count == 0 && words_out == words_in) begin
            $display("line_rasterizer_wrapped regression: pass");
        end else begin
            $display("line_rasterizer_wrapped regression: fail");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("line_rasterizer_wrapped regression: fail");
        $finish;
    end

endmodule

// File: line_rasterizer_wrapped.f
rtl/lr_pkg.sv
rtl/lr_walker.sv
rtl/lr_addr_map.sv
rtl/line_rasterizer_wrapped.sv
tb/line_rasterizer_checker.sv
tb/line_rasterizer_wrapped_tb.sv
